FILE: design/f2r_pkg.sv
`default_nettype none
package f2r_pkg;
	localparam int MaxTermsDefault = 64;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UFLOW = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_STRIP,
		S_TERM,
		S_DIV1,
		S_CHECK,
		S_MULA,
		S_TEST,
		S_SEMI,
		S_DIV2,
		S_LAST,
		S_MULH,
		S_WAITH,
		S_MULK,
		S_WAITK,
		S_REM,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

FILE: design/f2r_div.sv
`default_nettype none
module f2r_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             busy,
	output logic [63:0]      quot,
	output logic [63:0]      rem
);
	logic [63:0] q_q;
	logic [63:0] r_q;
	logic [63:0] d_q;
	logic [6:0]  cnt_q;
	logic [64:0] trial;

	assign trial = {r_q, q_q[63]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[64]) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= {r_q[62:0], q_q[63]};
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = q_q;
	assign rem  = r_q;
endmodule
`default_nettype wire

FILE: design/float_to_rational_approx_unit.sv
`default_nettype none
// Best rational approximation of a binary64 value under a denominator limit, by continued
// fractions with a semiconvergent check, at most MAX_TERMS terms. One item at a time:
// in_ready is low from the input transfer until the result has been taken. NaN, infinity,
// saturated values, truncation mode (max_denom 0 or 1) and integers finish at the input
// transfer, with out_valid high on the next cycle. A non-integer first strips trailing zero
// bits of the significand, one per cycle, and finishes with underflow status if the reduced
// denominator still exceeds 2^62; else it runs the expansion on one shared radix-2 divider
// and a 32x32 multiplier used three times per 64-bit product. The term that ends on the
// semiconvergent check can add a second divide. The result waits in an output register
// until taken.
module float_to_rational_approx_unit #(
	parameter int MAX_TERMS = f2r_pkg::MaxTermsDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [63:0]        float_bits,
	input  wire logic [62:0]        max_denom,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [63:0]      numerator,
	output logic [62:0]             denominator,
	output logic [1:0]              status
);
	import f2r_pkg::*;

	localparam int TW = $clog2(MAX_TERMS + 1);

	state_t state_q, state_d;
	logic        neg_q;
	logic [63:0] md_q, mant_q, d_q, n_q, a_q, x_q;
	logic [63:0] h0_q, h1_q, k0_q, k1_q;
	logic [10:0] sh_q;
	logic        last_q;
	logic [TW-1:0] i_q;
	logic [63:0] num_q;
	logic [62:0] den_q;
	status_t     st_q;
	logic        ov_q;
	logic        ov_set;

	logic        dv_start, dv_busy;
	logic [63:0] dv_a, dv_b, dv_q, dv_r;

	f2r_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_a),
		.divisor(dv_b), .busy(dv_busy), .quot(dv_q), .rem(dv_r)
	);

	logic [10:0] ex;
	logic [63:0] mnt;
	logic signed [12:0] e;
	logic [12:0] nege;
	assign ex   = float_bits[62:52];
	assign mnt  = {11'd0, (ex != 11'd0), float_bits[51:0]};
	assign e    = (ex == 11'd0) ? -13'sd1074 : $signed({2'b00, ex}) - 13'sd1075;
	assign nege = 13'(-e);

	logic [63:0] mag;
	always_comb begin
		if (e >= 13'sd0) mag = mnt << e[5:0];
		else if (nege > 13'd63) mag = '0;
		else mag = mnt >> nege[5:0];
	end

	logic [63:0] shmask;
	assign shmask = (64'd1 << nege[5:0]) - 64'd1;

	logic accept, is_nonfin, is_sat, is_int, trunc;
	assign accept    = in_valid && in_ready;
	assign is_nonfin = (ex == 11'h7ff);
	assign is_sat    = (mnt != 64'd0) && (e >= 13'sd11);
	assign trunc     = (max_denom <= 63'd1);
	assign is_int    = (mnt == 64'd0) || (e >= 13'sd0) ||
		(nege <= 13'd63 && (mnt & shmask) == 64'd0);

	// shared 32x32 multiplier, low 64 bits of a 64x64 product in three steps
	logic        mul_start, mul_busy;
	logic [63:0] mul_a, mul_b, mul_p;
	logic [1:0]  mcnt_q;
	logic [63:0] ma_q, mb_q, macc_q;
	logic [31:0] mop_a, mop_b;
	logic [63:0] mpp;

	always_comb begin
		case (mcnt_q)
			2'd2:    begin mop_a = ma_q[31:0];  mop_b = mb_q[63:32]; end
			2'd1:    begin mop_a = ma_q[63:32]; mop_b = mb_q[31:0];  end
			default: begin mop_a = ma_q[31:0];  mop_b = mb_q[31:0];  end
		endcase
	end

	assign mpp = {32'd0, mop_a} * {32'd0, mop_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (mul_start) begin
			mcnt_q <= 2'd3;
		end else if (mcnt_q != 2'd0) begin
			mcnt_q <= mcnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_start) begin
			ma_q <= mul_a;
			mb_q <= mul_b;
		end else if (mcnt_q == 2'd3) begin
			macc_q <= mpp;
		end else if (mcnt_q != 2'd0) begin
			macc_q <= macc_q + {mpp[31:0], 32'd0};
		end
	end

	assign mul_busy = (mcnt_q != 2'd0);
	assign mul_p    = macc_q;

	logic semi, keep_semi;
	assign semi      = (mul_p + k0_q) >= md_q;
	assign keep_semi = ((x_q << 1) >= a_q) || (k1_q >= md_q);

	always_comb begin
		state_d   = state_q;
		ov_set    = 1'b0;
		dv_start  = 1'b0;
		dv_a      = d_q;
		dv_b      = n_q;
		mul_start = 1'b0;
		mul_a     = k1_q;
		mul_b     = dv_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_nonfin || is_sat || trunc || is_int) ov_set = 1'b1;
					else state_d = S_STRIP;
				end
			end
			S_STRIP: begin
				if (mant_q[0]) begin
					if (sh_q > 11'd62) begin
						ov_set  = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_TERM;
					end
				end
			end
			S_TERM: begin
				dv_start = 1'b1;
				state_d  = S_DIV1;
			end
			S_DIV1: if (!dv_busy) state_d = S_CHECK;
			S_CHECK: begin
				if (i_q != '0 && dv_q == 64'd0) begin
					state_d = S_DONE;
				end else begin
					mul_start = 1'b1;
					state_d   = S_MULA;
				end
			end
			S_MULA: if (!mul_busy) state_d = S_TEST;
			S_TEST: state_d = semi ? S_SEMI : S_MULH;
			S_SEMI: begin
				if (k1_q == 64'd0 || md_q < k0_q) begin
					state_d = S_LAST;
				end else begin
					dv_start = 1'b1;
					dv_a     = md_q - k0_q;
					dv_b     = k1_q;
					state_d  = S_DIV2;
				end
			end
			S_DIV2: if (!dv_busy) state_d = S_LAST;
			S_LAST: state_d = keep_semi ? S_MULH : S_DONE;
			S_MULH: begin
				mul_start = 1'b1;
				mul_a     = x_q;
				mul_b     = h1_q;
				state_d   = S_WAITH;
			end
			S_WAITH: if (!mul_busy) state_d = S_MULK;
			S_MULK: begin
				mul_start = 1'b1;
				mul_a     = x_q;
				mul_b     = k1_q;
				state_d   = S_WAITK;
			end
			S_WAITK: if (!mul_busy) state_d = last_q ? S_DONE : S_REM;
			S_REM: begin
				if (dv_r == 64'd0 || i_q == TW'(MAX_TERMS - 1)) state_d = S_DONE;
				else state_d = S_TERM;
			end
			S_DONE: begin
				ov_set  = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready = (state_q == S_IDLE) && !ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ov_set) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					neg_q  <= float_bits[63];
					md_q   <= {1'b0, max_denom};
					mant_q <= mnt;
					sh_q   <= nege[10:0];
					h0_q <= '0; h1_q <= 64'd1; k0_q <= 64'd1; k1_q <= '0;
					last_q <= 1'b0;
					i_q    <= '0;
					den_q  <= 63'd1;
					if (is_nonfin) begin
						num_q <= '0; st_q <= ST_UFLOW;
					end else if (is_sat) begin
						num_q <= float_bits[63] ? 64'h8000000000000000 : 64'h7fffffffffffffff;
						st_q  <= ST_SAT;
					end else begin
						num_q <= float_bits[63] ? -mag : mag;
						st_q  <= ST_OK;
					end
				end
			end
			S_STRIP: begin
				if (!mant_q[0]) begin
					mant_q <= mant_q >> 1;
					sh_q   <= sh_q - 11'd1;
				end else if (sh_q > 11'd62) begin
					num_q <= '0; den_q <= 63'd1; st_q <= ST_UFLOW;
				end else begin
					d_q <= mant_q;
					n_q <= 64'd1 << sh_q[5:0];
				end
			end
			S_CHECK: a_q <= dv_q;
			S_TEST: if (!semi) x_q <= a_q;
			S_SEMI: if (k1_q == 64'd0 || md_q < k0_q) x_q <= '0;
			S_DIV2: if (!dv_busy) x_q <= dv_q;
			S_LAST: if (keep_semi) last_q <= 1'b1;
			S_WAITH: begin
				if (!mul_busy) begin
					h1_q <= mul_p + h0_q;
					h0_q <= h1_q;
				end
			end
			S_WAITK: begin
				if (!mul_busy) begin
					k1_q <= mul_p + k0_q;
					k0_q <= k1_q;
				end
			end
			S_REM: begin
				d_q <= n_q;
				n_q <= dv_r;
				i_q <= i_q + TW'(1);
			end
			S_DONE: begin
				num_q <= neg_q ? -h1_q : h1_q;
				den_q <= k1_q[62:0];
				st_q  <= ST_OK;
			end
			default: ;
		endcase
	end

	assign out_valid   = ov_q;
	assign numerator   = num_q;
	assign denominator = den_q;
	assign status      = st_q;
endmodule
`default_nettype wire
